// ===== rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the config byte descrambler
// Transfer payloads, output slot type, delta and block reorder tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

   // Bytes in one reorder block
   localparam int BLOCK_BYTES = 8;
   localparam int IDX_W       = $clog2(BLOCK_BYTES);

   // Register indexes of the write port
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_KEY    = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       last_out;
   } rsp_type;

   // One slot of the output chain
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } slot_type;

   // Per-position correction, by fill position within the block mod 4
   function automatic logic [7:0] delta_for(input logic [1:0] pos);
      logic [7:0] d;
      case (pos)
         2'd0:    d = 8'd1;
         2'd1:    d = 8'd3;
         2'd2:    d = 8'd254;
         2'd3:    d = 8'd4;
         default: d = 8'd0;
      endcase
      return d;
   endfunction

   // Source byte within the block for output position j
   function automatic logic [IDX_W-1:0] perm_src(input logic [IDX_W-1:0] j);
      logic [IDX_W-1:0] s;
      case (j)
         3'd0:    s = 3'd3;
         3'd1:    s = 3'd6;
         3'd2:    s = 3'd2;
         3'd3:    s = 3'd5;
         3'd4:    s = 3'd0;
         3'd5:    s = 3'd7;
         3'd6:    s = 3'd4;
         3'd7:    s = 3'd1;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cbd_cell.sv =====
// ----------------------------------------------------------------------------
// cbd_cell: one slot of the output chain
// Loads a fresh result in parallel or takes its neighbor's slot on a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_cell
   import cbd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire logic     shift,
   input  wire slot_type load_slot,
   input  wire slot_type next_slot,
   output slot_type      slot
);

   slot_type slot_ff;
   slot_type slot_in;

   // Load wins over shift; otherwise hold
   always_comb begin
      slot_in = slot_ff;
      if (load) begin
         slot_in = load_slot;
      end else if (shift) begin
         slot_in = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.data <= slot_in.data;
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ===== rtl/cbd_gather.sv =====
// ----------------------------------------------------------------------------
// cbd_gather: block fill buffer and chain load composer
// Applies the delta pass, collects a block and builds keyed slots, reordered
// if full, that the chain loads when a group closes; disabled, bytes pass raw.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_gather
   import cbd_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          enable,
   input  wire logic [31:0]                   key,
   input  wire req_type                       req,
   output logic                               closes,
   output slot_type [BLOCK_BYTES-1:0]         load_slots
);

   logic [IDX_W-1:0] fill_ff;
   logic [IDX_W-1:0] fill_in;
   logic [7:0]       buf_ff [BLOCK_BYTES];
   logic [7:0]       cur_byte;
   logic             full;

   assign cur_byte = req.data_byte + delta_for(fill_ff[1:0]);
   assign full     = (fill_ff == IDX_W'(BLOCK_BYTES - 1));
   assign closes   = !enable || req.last_in || full;

   // Advance or restart the fill position
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (closes) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Store the corrected byte at the fill position
   always_ff @(posedge clock) begin
      if (accept && enable) begin
         buf_ff[fill_ff] <= cur_byte;
      end
   end

   // Compose one slot per output position
   always_comb begin
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] src;
      logic [7:0]       b;
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         pos = IDX_W'(j);
         src = full ? perm_src(pos) : pos;
         if (src == fill_ff) begin
            b = cur_byte;
         end else if (full) begin
            b = buf_ff[perm_src(pos)];
         end else begin
            b = buf_ff[pos];
         end
         if (!enable) begin
            load_slots[j].valid           = (j == 0);
            load_slots[j].data.plain_byte = req.data_byte;
            load_slots[j].data.last_out   = req.last_in;
         end else begin
            load_slots[j].valid           = full || (pos <= fill_ff);
            load_slots[j].data.plain_byte = b ^ key[8*(j%4) +: 8];
            load_slots[j].data.last_out   = full ? ((j == BLOCK_BYTES - 1) && req.last_in)
                                                 : (pos == fill_ff);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/config_byte_descrambler.sv =====
// Output: results of a group start in the cycle after the byte that closes it.
// Throughput: one byte per cycle; a full block drains its eight results while
// the next block fills. A byte that closes a group waits until the output
// chain of eight cells holds at most its final, departing result.
// Reset: synchronous; clears the fill count, the chain, enable to 1, key to 0.
// ----------------------------------------------------------------------------
// config_byte_descrambler: three-pass byte stream descrambler
// Delta correction, reorder of full eight-byte blocks and key XOR, with an
// output chain of cells shifting one result per transfer; bypass if disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module config_byte_descrambler
   import cbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data
);

   logic                       enable_ff;
   logic [31:0]                key_ff;
   logic                       req_xfer;
   logic                       rsp_xfer;
   logic                       closes;
   logic                       room;
   logic                       load;
   slot_type [BLOCK_BYTES-1:0] load_slots;
   slot_type                   chain [BLOCK_BYTES];
   slot_type                   next_of [BLOCK_BYTES];
   logic [BLOCK_BYTES-1:0]     chain_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         key_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_KEY:    key_ff    <= csr_data;
            default:    ;
         endcase
      end
   end

   // Handshake: a group may load only when the chain is empty or draining its last
   assign rsp_valid = chain[0].valid;
   assign rsp_data  = chain[0].data;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign room      = !chain[0].valid || (!chain[1].valid && rsp_xfer);
   assign req_stall = closes && !room;
   assign req_xfer  = req_valid && !req_stall;
   assign load      = req_xfer && closes;

   cbd_gather u_gather (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_xfer),
      .enable     (enable_ff),
      .key        (key_ff),
      .req        (req_data),
      .closes     (closes),
      .load_slots (load_slots)
   );

   // Output chain of cells
   for (genvar i = 0; i < BLOCK_BYTES; i++) begin : g_chain
      if (i == BLOCK_BYTES - 1) begin : g_tail
         assign next_of[i] = '0;
      end else begin : g_body
         assign next_of[i] = chain[i+1];
      end
      assign chain_valid[i] = chain[i].valid;

      cbd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .shift     (rsp_xfer),
         .load_slot (load_slots[i]),
         .next_slot (next_of[i]),
         .slot      (chain[i])
      );
   end

`ifndef ASSERT_OFF
   // Occupied slots stay packed toward the output end
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((chain_valid & (chain_valid + 1'b1)) == '0))
      else $error("output chain has a gap");

   // A load never overwrites a result that is still owed
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!chain[0].valid || (!chain[1].valid && rsp_xfer)))
      else $error("chain loaded over pending results");

   // A closing byte always produces at least one result next cycle
   a_group_emits: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("closed group produced no result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_config_byte_descrambler.sv =====
// ----------------------------------------------------------------------------
// tb_config_byte_descrambler: self-checking bench of the byte descrambler
// Drives a directed script and then random payloads through the request
// channel, predicts each result from a behavioral copy of the delta, block
// reorder and key passes or a typed script answer, and compares each response
// transfer in order. Receiver stalls are random; random phases add sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_config_byte_descrambler;
   import cbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 100;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASES        = 8;
   localparam int PHASE_BYTES   = 40;

   // Correction per position mod 4, and source byte per output slot of a block
   localparam logic [31:0] DELTA_TAB   = {8'd4, 8'd254, 8'd3, 8'd1};
   localparam logic [23:0] SWIZZLE_TAB = {3'd1, 3'd4, 3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd3};

   typedef enum logic [1:0] {ROW_BYTE, ROW_ENABLE, ROW_KEY} row_kind_type;
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_THIRD,
      STALL_QUARTER
   } stall_mode_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      logic         last;
      logic         typed;
      logic [7:0]   typed_byte;
   } script_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_write  = 1'b0;
   logic        csr_index  = CSR_ENABLE;
   logic [31:0] csr_data   = '0;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   req_type     req_data   = '0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   rsp_type     rsp_data;

   // Behavioral state of the block
   logic [7:0]  blk_bytes [8];
   int          blk_fill;
   logic        mdl_enable;
   logic [31:0] mdl_key;

   rsp_type        plain_q [$];
   script_row_type script [$];
   int             errors   = 0;
   bit             hold_req = 1'b0;
   rsp_type        want;

   config_byte_descrambler i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic script_row_type mk_row(input row_kind_type kind,
                                             input logic [31:0] value,
                                             input logic last, input logic typed,
                                             input logic [7:0] typed_byte);
      script_row_type r;
      r.kind       = kind;
      r.value      = value;
      r.last       = last;
      r.typed      = typed;
      r.typed_byte = typed_byte;
      return r;
   endfunction

   // Work out the results of one accepted byte and queue them
   task automatic descramble_byte(input req_type r, input logic typed,
                                  input logic [7:0] typed_byte);
      rsp_type grp [$];
      rsp_type res;
      int      n;
      if (!mdl_enable) begin
         blk_fill       = 0;
         res.plain_byte = r.data_byte;
         res.last_out   = r.last_in;
         grp.push_back(res);
      end else begin
         n            = blk_fill;
         blk_bytes[n] = r.data_byte + DELTA_TAB[8 * (n % 4) +: 8];
         n++;
         if (n == 8) begin
            // full block: reorder, then key by output slot
            for (int j = 0; j < 8; j++) begin
               res.plain_byte = blk_bytes[SWIZZLE_TAB[3 * j +: 3]] ^ mdl_key[8 * (j % 4) +: 8];
               res.last_out   = r.last_in && (j == 7);
               grp.push_back(res);
            end
            blk_fill = 0;
         end else if (r.last_in) begin
            // trailing partial block keeps its order
            for (int j = 0; j < n; j++) begin
               res.plain_byte = blk_bytes[j] ^ mdl_key[8 * (j % 4) +: 8];
               res.last_out   = (j == n - 1);
               grp.push_back(res);
            end
            blk_fill = 0;
         end else begin
            blk_fill = n;
         end
      end
      // a row with a hand-written answer overrides the computed one
      if (typed && grp.size() > 0) begin
         grp[0].plain_byte = typed_byte;
         grp[0].last_out   = r.last_in;
      end
      foreach (grp[i]) plain_q.push_back(grp[i]);
   endtask

   // Offer one byte and hold it until the transfer completes
   task automatic offer_byte(input req_type r, input logic typed, input logic [7:0] typed_byte);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      descramble_byte(r, typed, typed_byte);
   endtask

   // Write a register once all pending results have drained
   task automatic write_reg(input logic idx, input logic [31:0] val);
      req_valid <= 1'b0;
      while (plain_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ENABLE) mdl_enable = val[0];
      else mdl_key = val;
   endtask

   // Stimulus: directed script, then random phases
   initial begin : stimulus
      req_type        r;
      script_row_type row;
      int             burst_left;
      int             gap;
      int             pay_left;
      logic [31:0]    key;
      logic           en;

      blk_fill   = 0;
      mdl_enable = 1'b1;
      mdl_key    = '0;
      foreach (blk_bytes[i]) blk_bytes[i] = '0;

      // single-byte payloads right after reset: position 0 correction only
      script.push_back(mk_row(ROW_BYTE, 32'hFF, 1'b1, 1'b1, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h00, 1'b1, 1'b1, 8'h01));
      // full block closed by the last byte, zero key
      script.push_back(mk_row(ROW_BYTE, 32'hFF, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h80, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h7F, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h01, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'hFE, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'hAA, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h55, 1'b1, 1'b0, 8'h00));
      // all-ones key on a partial block
      script.push_back(mk_row(ROW_KEY, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h12, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h34, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h56, 1'b1, 1'b0, 8'h00));
      // key changed while a block is partly filled
      script.push_back(mk_row(ROW_KEY, 32'h0000_5445, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'hFF, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_KEY, 32'hA5C3_0F96, 1'b0, 1'b0, 8'h00));
      for (int i = 1; i <= 6; i++)
         script.push_back(mk_row(ROW_BYTE, 32'h10 * i, 1'b0, 1'b0, 8'h00));
      // partial block dropped by disabling, then pass-through
      script.push_back(mk_row(ROW_BYTE, 32'h77, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h88, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_ENABLE, 32'h0, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'hA5, 1'b0, 1'b1, 8'hA5));
      script.push_back(mk_row(ROW_BYTE, 32'h5A, 1'b1, 1'b1, 8'h5A));
      script.push_back(mk_row(ROW_ENABLE, 32'h1, 1'b0, 1'b0, 8'h00));
      script.push_back(mk_row(ROW_BYTE, 32'h01, 1'b1, 1'b0, 8'h00));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         case (row.kind)
            ROW_ENABLE: write_reg(CSR_ENABLE, row.value);
            ROW_KEY:    write_reg(CSR_KEY, row.value);
            default: begin
               r.data_byte = row.value[7:0];
               r.last_in   = row.last;
               offer_byte(r, row.typed, row.typed_byte);
            end
         endcase
      end

      // random phases, each with its own register setting
      burst_left = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin en = 1'b1; key = 32'h0;         end
            1:       begin en = 1'b1; key = 32'hFFFF_FFFF; end
            3:       begin en = 1'b0; key = $urandom;      end
            4:       begin en = 1'b1; key = 32'h0000_5445; end
            default: begin en = ($urandom_range(0, 4) != 0); key = $urandom; end
         endcase
         write_reg(CSR_KEY, key);
         write_reg(CSR_ENABLE, {31'b0, en});
         if (ph == 1) hold_req = 1'b1;
         pay_left = $urandom_range(1, 20);
         for (int i = 0; i < PHASE_BYTES; i++) begin
            // once, let every pending result drain before going on
            if (ph == 2 && i == PHASE_BYTES / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (plain_q.size() != 0);
            end
            // bursts of random length with random gaps
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            pay_left--;
            r.data_byte = 8'($urandom_range(0, 255));
            // mostly well-formed payloads, some stray last markers
            if ($urandom_range(0, 7) == 0) r.last_in = 1'($urandom_range(0, 1));
            else r.last_in = (pay_left <= 0);
            if (i == PHASE_BYTES - 1) r.last_in = 1'b1;
            if (r.last_in) pay_left = $urandom_range(1, 20);
            offer_byte(r, 1'b0, 8'h00);
         end
      end

      // drain and look for strays
      req_valid <= 1'b0;
      while (plain_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && plain_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: stall on changing patterns, with one long hold on request
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      bit             held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(1, 40);
         for (int k = 0; k < span; k++) begin
            // start the long hold as soon as it is asked for
            if (hold_req && !held) break;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
               STALL_THIRD: rsp_stall <= (k % 3 == 0);
               default:     rsp_stall <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plain_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got byte %02h last %0b",
                     $time, rsp_data.plain_byte, rsp_data.last_out);
         end else begin
            want = plain_q.pop_front();
            if (rsp_data.plain_byte !== want.plain_byte) begin
               errors++;
               $display("%0t: plain_byte expected %02h, got %02h",
                        $time, want.plain_byte, rsp_data.plain_byte);
            end
            if (rsp_data.last_out !== want.last_out) begin
               errors++;
               $display("%0t: last_out expected %0b, got %0b",
                        $time, want.last_out, rsp_data.last_out);
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, plain_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
